>>> hdl/bpsu_pkg.sv
// Shared types, constants and rounding helpers of the beam source pose unit.
package bpsu_pkg;

  // Default parameter values and the working fraction width.
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int VECTOR_FRAC_DEF   = 30;
  localparam int WORK_FRAC         = 32;

  // Field widths.
  localparam int ANG_W     = 18;
  localparam int ANG_SUM_W = 20;
  localparam int OFS_W     = 21;
  localparam int LEN_W     = 24;
  localparam int ORG_W     = 27;
  localparam int VEC_W     = 32;
  localparam int XY_W      = 35;
  localparam int Z_W       = 33;
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 376;

  // Angles are degrees with 8 fraction bits.
  localparam int DEG_FULL    = 92160;
  localparam int DEG_HALF    = 46080;
  localparam int DEG_QUARTER = 23040;

  // Inverse CORDIC gain with 32 fraction bits.
  localparam logic signed [XY_W-1:0] CORDIC_START = 35'sd2608131496;

  // atan(2^-i) in degrees with 24 fraction bits.
  localparam logic signed [Z_W-1:0] ATAN_TAB [32] = '{
    33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
    33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
    33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
    33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
    33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
    33'sd917,       33'sd458,       33'sd229,       33'sd115,
    33'sd57,        33'sd29,        33'sd14,        33'sd7,
    33'sd4,         33'sd2,         33'sd1,         33'sd0
  };

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ISO_X       = 3'd0,
    REG_ISO_Y       = 3'd1,
    REG_ISO_Z       = 3'd2,
    REG_SAD         = 3'd3,
    REG_FRAME_MODE  = 3'd4,
    REG_DEF_GANTRY  = 3'd5,
    REG_DEF_COUCH   = 3'd6,
    REG_DEF_COLLIM  = 3'd7
  } reg_idx_e;

  // Patient orientation codes in frame_mode bits 1:0.
  typedef enum logic [1:0] {
    POS_HFS = 2'd0,
    POS_HFP = 2'd1,
    POS_FFS = 2'd2,
    POS_FFP = 2'd3
  } pos_e;

  // frame_mode bit that selects the patient-Z convention.
  localparam int MODE_PZ_BIT = 2;

  // State carried from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
  } cordic_t;

  // Static frame settings used by the matrix and origin stages.
  typedef struct packed {
    logic signed [LEN_W-1:0] iso_x;
    logic signed [LEN_W-1:0] iso_y;
    logic signed [LEN_W-1:0] iso_z;
    logic        [LEN_W-1:0] sad;
    logic        [2:0]       mode;
  } frame_cfg_t;

  // One result; origin_x sits in the lowest bits.
  typedef struct packed {
    logic signed [VEC_W-1:0] axis_w_z;
    logic signed [VEC_W-1:0] axis_w_y;
    logic signed [VEC_W-1:0] axis_w_x;
    logic signed [VEC_W-1:0] axis_v_z;
    logic signed [VEC_W-1:0] axis_v_y;
    logic signed [VEC_W-1:0] axis_v_x;
    logic signed [VEC_W-1:0] axis_u_z;
    logic signed [VEC_W-1:0] axis_u_y;
    logic signed [VEC_W-1:0] axis_u_x;
    logic signed [ORG_W-1:0] origin_z;
    logic signed [ORG_W-1:0] origin_y;
    logic signed [ORG_W-1:0] origin_x;
  } result_t;

  // Round half up by sh bits, then clamp to plus or minus 2^f.
  function automatic logic signed [VEC_W-1:0] round_clamp(
    input logic signed [67:0] v,
    input int unsigned        sh,
    input int unsigned        f
  );
    logic signed [67:0] r;
    logic signed [67:0] one;
    logic signed [67:0] neg_one;
    r       = (v + (68'sd1 <<< (sh - 1))) >>> sh;
    one     = 68'sd1 <<< f;
    neg_one = -one;
    if (r > one) begin
      return one[VEC_W-1:0];
    end else if (r < neg_one) begin
      return neg_one[VEC_W-1:0];
    end
    return r[VEC_W-1:0];
  endfunction

  // Rows whose sign the patient orientation flips.
  function automatic logic row_flip(input pos_e pos, input int unsigned row);
    logic flip;
    flip = 1'b0;
    unique case (pos)
      POS_HFS: flip = 1'b0;
      POS_HFP: flip = (row == 0) || (row == 1);
      POS_FFS: flip = (row == 0) || (row == 2);
      POS_FFP: flip = (row == 1) || (row == 2);
      default: flip = 1'b0;
    endcase
    return flip;
  endfunction

endpackage

>>> hdl/bpsu_angle_prep.sv
// Angle reduction to one half turn and CORDIC start values, two stages.
module bpsu_angle_prep (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [bpsu_pkg::ANG_SUM_W-1:0] ang_i,
  output bpsu_pkg::cordic_t                     cell_o
);

  logic        [16:0] red_d, red_q;
  logic signed [21:0] cand [6];
  logic signed [18:0] fold;
  logic               neg_d;
  bpsu_pkg::cordic_t  cell_d, cell_q;

  // Stage one: pick the one of six turn offsets that lands in [0, 360).
  always_comb begin
    red_d = '0;
    for (int k = 0; k < 6; k++) begin
      cand[k] = 22'(ang_i) + 22'((k - 2) * bpsu_pkg::DEG_FULL);
      if (!cand[k][21] && (cand[k] < 22'sd92160)) begin
        red_d = cand[k][16:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q <= red_d;
    end
  end

  // Stage two: fold into plus or minus a quarter turn, noting a sign flip.
  always_comb begin
    fold  = 19'(signed'({1'b0, red_q}));
    neg_d = 1'b0;
    if (fold > 19'sd46080) begin
      fold = fold - 19'sd92160;
    end
    if (fold > 19'sd23040) begin
      fold  = fold - 19'sd46080;
      neg_d = 1'b1;
    end else if (fold < -19'sd23040) begin
      fold  = fold + 19'sd46080;
      neg_d = 1'b1;
    end
    cell_d.x   = bpsu_pkg::CORDIC_START;
    cell_d.y   = '0;
    cell_d.z   = bpsu_pkg::Z_W'(fold) <<< 16;
    cell_d.neg = neg_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> hdl/bpsu_cordic_cell.sv
// One CORDIC micro-rotation with its output register.
module bpsu_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  bpsu_pkg::cordic_t cell_i,
  output bpsu_pkg::cordic_t cell_o
);

  logic signed [bpsu_pkg::XY_W-1:0] x_in, y_in, dx, dy;
  logic signed [bpsu_pkg::Z_W-1:0]  z_in;
  bpsu_pkg::cordic_t                cell_d, cell_q;

  // Rotate toward zero residual angle.
  always_comb begin
    x_in = cell_i.x;
    y_in = cell_i.y;
    z_in = cell_i.z;
    dx   = y_in >>> STAGE;
    dy   = x_in >>> STAGE;
    cell_d.neg = cell_i.neg;
    if (!z_in[bpsu_pkg::Z_W-1]) begin
      cell_d.x = x_in - dx;
      cell_d.y = y_in + dy;
      cell_d.z = z_in - bpsu_pkg::ATAN_TAB[STAGE];
    end else begin
      cell_d.x = x_in + dx;
      cell_d.y = y_in - dy;
      cell_d.z = z_in + bpsu_pkg::ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> hdl/bpsu_frame.sv
// Rotation matrix build, orientation signs and source origin, eight stages.
module bpsu_frame #(
  parameter int VECTOR_FRAC_BITS = bpsu_pkg::VECTOR_FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  bpsu_pkg::frame_cfg_t              cfg_i,
  input  bpsu_pkg::cordic_t                 col_i,
  input  bpsu_pkg::cordic_t                 rot_i,
  input  bpsu_pkg::cordic_t                 cou_i,
  input  logic signed [bpsu_pkg::OFS_W-1:0] ofs_u_i,
  input  logic signed [bpsu_pkg::OFS_W-1:0] ofs_v_i,
  output bpsu_pkg::result_t                 res_o
);

  localparam int F  = VECTOR_FRAC_BITS;
  localparam int SH = bpsu_pkg::WORK_FRAC - VECTOR_FRAC_BITS;
  localparam int VW = bpsu_pkg::VEC_W;
  localparam int OW = bpsu_pkg::OFS_W;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [63:0]   prod_t;

  logic pz;
  assign pz = cfg_i.mode[bpsu_pkg::MODE_PZ_BIT];

  // Stage F0: CORDIC outputs to unit vectors.
  vec_t cc_q, sc_q, cb_q, sb_q, cz_q, sz_q;
  logic signed [OW-1:0] ou0_q, ov0_q;

  function automatic vec_t unit_of(input logic signed [bpsu_pkg::XY_W-1:0] v,
                                   input logic neg);
    logic signed [67:0] w;
    w = 68'(v);
    if (neg) begin
      w = -w;
    end
    return bpsu_pkg::round_clamp(w, SH, F);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q  <= unit_of(col_i.x, col_i.neg);
      sc_q  <= unit_of(col_i.y, col_i.neg);
      cb_q  <= unit_of(rot_i.x, rot_i.neg);
      sb_q  <= unit_of(rot_i.y, rot_i.neg);
      cz_q  <= unit_of(cou_i.x, cou_i.neg);
      sz_q  <= unit_of(cou_i.y, cou_i.neg);
      ou0_q <= ofs_u_i;
      ov0_q <= ofs_v_i;
    end
  end

  // Stage M1: first products; the IEC form uses minus the gantry sine.
  prod_t p_q [4];
  vec_t  cc1_q, sc1_q, cb1_q, sb1_q, cz1_q, sz1_q;
  logic signed [OW-1:0] ou1_q, ov1_q;
  vec_t  sbx;

  assign sbx = pz ? sb_q : -sb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= cb_q * cc_q;
      p_q[1] <= cb_q * sc_q;
      p_q[2] <= sbx * cc_q;
      p_q[3] <= sbx * sc_q;
      cc1_q  <= cc_q;
      sc1_q  <= sc_q;
      cb1_q  <= cb_q;
      sb1_q  <= sb_q;
      cz1_q  <= cz_q;
      sz1_q  <= sz_q;
      ou1_q  <= ou0_q;
      ov1_q  <= ov0_q;
    end
  end

  // Stage M2: round the products and lay out the intermediate matrix.
  vec_t t_d [3][3];
  vec_t t_q [3][3];
  vec_t q [4];
  vec_t cz2_q, sz2_q;
  logic signed [OW-1:0] ou2_q, ov2_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q[i] = bpsu_pkg::round_clamp(68'(p_q[i]), F, F);
    end
    t_d[0][0] = q[0];
    t_d[0][1] = q[1];
    t_d[0][2] = sb1_q;
    if (pz) begin
      t_d[1][0] = q[2];
      t_d[1][1] = q[3];
      t_d[1][2] = -cb1_q;
      t_d[2][0] = -sc1_q;
      t_d[2][1] = cc1_q;
      t_d[2][2] = '0;
    end else begin
      t_d[1][0] = -sc1_q;
      t_d[1][1] = cc1_q;
      t_d[1][2] = '0;
      t_d[2][0] = q[2];
      t_d[2][1] = q[3];
      t_d[2][2] = cb1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= t_d;
      cz2_q <= cz1_q;
      sz2_q <= sz1_q;
      ou2_q <= ou1_q;
      ov2_q <= ov1_q;
    end
  end

  // Stage M3: couch rotation products for the IEC form.
  prod_t pa_q [3], pb_q [3], pd_q [3], pe_q [3];
  vec_t  t3_q [3][3];
  logic signed [OW-1:0] ou3_q, ov3_q;
  vec_t  szn;

  assign szn = -sz2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        pa_q[c] <= cz2_q * t_q[0][c];
        pb_q[c] <= szn * t_q[1][c];
        pd_q[c] <= sz2_q * t_q[0][c];
        pe_q[c] <= cz2_q * t_q[1][c];
      end
      t3_q  <= t_q;
      ou3_q <= ou2_q;
      ov3_q <= ov2_q;
    end
  end

  // Stage M4: sums of the couch rotation; patient-Z passes its matrix on.
  vec_t m_d [3][3];
  vec_t m_q [3][3];
  logic signed [OW-1:0] ou4_q, ov4_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (pz) begin
        m_d[0][c] = t3_q[0][c];
        m_d[1][c] = t3_q[1][c];
      end else begin
        m_d[0][c] = bpsu_pkg::round_clamp(68'(pa_q[c]) + 68'(pb_q[c]), F, F);
        m_d[1][c] = bpsu_pkg::round_clamp(68'(pd_q[c]) + 68'(pe_q[c]), F, F);
      end
      m_d[2][c] = t3_q[2][c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q   <= m_d;
      ou4_q <= ou3_q;
      ov4_q <= ov3_q;
    end
  end

  // Stage O0: patient orientation signs; w is minus the third column.
  vec_t u_q [3], v_q [3], w_q [3];
  logic signed [OW-1:0] ou5_q, ov5_q;
  bpsu_pkg::pos_e pos;

  assign pos = bpsu_pkg::pos_e'(cfg_i.mode[1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        if (bpsu_pkg::row_flip(pos, r)) begin
          u_q[r] <= -m_q[r][0];
          v_q[r] <= -m_q[r][1];
          w_q[r] <= m_q[r][2];
        end else begin
          u_q[r] <= m_q[r][0];
          v_q[r] <= m_q[r][1];
          w_q[r] <= -m_q[r][2];
        end
      end
      ou5_q <= ou4_q;
      ov5_q <= ov4_q;
    end
  end

  // Stage O1: origin products.
  logic signed [56:0] sw_q [3];
  logic signed [52:0] pu_q [3], pv_q [3];
  vec_t u6_q [3], v6_q [3], w6_q [3];
  logic signed [bpsu_pkg::LEN_W:0] sad_s;

  assign sad_s = signed'({1'b0, cfg_i.sad});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        sw_q[r] <= 57'(sad_s) * 57'(w_q[r]);
        pu_q[r] <= 53'(ou5_q) * 53'(u_q[r]);
        pv_q[r] <= 53'(ov5_q) * 53'(v_q[r]);
      end
      u6_q <= u_q;
      v6_q <= v_q;
      w6_q <= w_q;
    end
  end

  // Stage O2: origin sum, rounding and saturation into the result register.
  logic signed [59:0] acc [3];
  logic signed [59:0] rnd [3];
  logic signed [bpsu_pkg::ORG_W-1:0] org [3];
  logic signed [bpsu_pkg::LEN_W-1:0] iso [3];
  bpsu_pkg::result_t res_d, res_q;

  assign iso[0] = cfg_i.iso_x;
  assign iso[1] = cfg_i.iso_y;
  assign iso[2] = cfg_i.iso_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = (60'(iso[r]) <<< F) - 60'(sw_q[r]) + 60'(pu_q[r]) + 60'(pv_q[r]);
      rnd[r] = (acc[r] + (60'sd1 <<< (F - 1))) >>> F;
      if (rnd[r] > 60'sd67108863) begin
        org[r] = 27'sd67108863;
      end else if (rnd[r] < -60'sd67108864) begin
        org[r] = -27'sd67108864;
      end else begin
        org[r] = rnd[r][bpsu_pkg::ORG_W-1:0];
      end
    end
    res_d.origin_x = org[0];
    res_d.origin_y = org[1];
    res_d.origin_z = org[2];
    res_d.axis_u_x = u6_q[0];
    res_d.axis_u_y = u6_q[1];
    res_d.axis_u_z = u6_q[2];
    res_d.axis_v_x = v6_q[0];
    res_d.axis_v_y = v6_q[1];
    res_d.axis_v_z = v6_q[2];
    res_d.axis_w_x = w6_q[0];
    res_d.axis_w_y = w6_q[1];
    res_d.axis_w_z = w6_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> hdl/beam_source_pose_unit.sv
// Top level of the beam source pose unit: config, CORDIC cell rows, frame stages.
//
//  channel  | direction | tdata / tuser                         | request taken when
//  s_axis   | in        | offsets and three angles / given flags | tvalid & tready
//  m_axis   | out       | origin and u, v, w unit vectors        | tvalid & tready
//  cfg      | in        | register index and data                | cfg_we_i
//
// One request enters per cycle unless a result waits untaken; each passes the
// angle reduction registers, the CORDIC cells, then the matrix and origin stages.
// The depth of the three CORDIC cell rows sets the latency.
// Reset clears the configuration registers and the valid line at once.
// While a result waits at the output, the whole pipeline holds.
module beam_source_pose_unit #(
  parameter int CORDIC_STAGES    = bpsu_pkg::CORDIC_STAGES_DEF,
  parameter int VECTOR_FRAC_BITS = bpsu_pkg::VECTOR_FRAC_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave tdata from bit 0: offset_u, offset_v, gantry_angle, couch_angle,
  // collimator_angle.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bpsu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Slave tuser from bit 0: gantry_given, couch_given, collimator_given.
  input  logic [bpsu_pkg::IN_USER_W-1:0]      s_axis_tuser,
  // Master tdata from bit 0: origin_x, origin_y, origin_z, axis_u_x, axis_u_y,
  // axis_u_z, axis_v_x, axis_v_y, axis_v_z, axis_w_x, axis_w_y, axis_w_z, zeros.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bpsu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_index_i,
  input  logic [bpsu_pkg::LEN_W-1:0]          cfg_data_i
);

  localparam int LAT  = CORDIC_STAGES + 10;
  localparam int SIDE = CORDIC_STAGES + 2;
  localparam int AW   = bpsu_pkg::ANG_W;
  localparam int SW   = bpsu_pkg::ANG_SUM_W;
  localparam int OW   = bpsu_pkg::OFS_W;
  localparam logic signed [bpsu_pkg::VEC_W-1:0] VEC_ONE = 32'sd1 <<< VECTOR_FRAC_BITS;

  // Configuration registers.
  logic signed [bpsu_pkg::LEN_W-1:0] iso_x_q, iso_y_q, iso_z_q;
  logic        [bpsu_pkg::LEN_W-1:0] sad_q;
  logic        [2:0]                 mode_q;
  logic signed [AW-1:0]              def_g_q, def_cu_q, def_co_q;
  bpsu_pkg::reg_idx_e                cfg_idx;

  assign cfg_idx = bpsu_pkg::reg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_x_q  <= '0;
      iso_y_q  <= '0;
      iso_z_q  <= '0;
      sad_q    <= '0;
      mode_q   <= '0;
      def_g_q  <= '0;
      def_cu_q <= '0;
      def_co_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        bpsu_pkg::REG_ISO_X:      iso_x_q  <= cfg_data_i;
        bpsu_pkg::REG_ISO_Y:      iso_y_q  <= cfg_data_i;
        bpsu_pkg::REG_ISO_Z:      iso_z_q  <= cfg_data_i;
        bpsu_pkg::REG_SAD:        sad_q    <= cfg_data_i;
        bpsu_pkg::REG_FRAME_MODE: mode_q   <= cfg_data_i[2:0];
        bpsu_pkg::REG_DEF_GANTRY: def_g_q  <= cfg_data_i[AW-1:0];
        bpsu_pkg::REG_DEF_COUCH:  def_cu_q <= cfg_data_i[AW-1:0];
        bpsu_pkg::REG_DEF_COLLIM: def_co_q <= cfg_data_i[AW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless the output holds a result not taken.
  logic           adv;
  logic [LAT-1:0] vld_q;

  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Angle selection from the request or from the defaults.
  logic signed [OW-1:0] ofs_u, ofs_v;
  logic signed [AW-1:0] ang_g, ang_cu, ang_co;
  logic signed [SW-1:0] ang_a, ang_b, ang_c;

  assign ofs_u  = s_axis_tdata[20:0];
  assign ofs_v  = s_axis_tdata[41:21];
  assign ang_g  = s_axis_tuser[0] ? s_axis_tdata[59:42] : def_g_q;
  assign ang_cu = s_axis_tuser[1] ? s_axis_tdata[77:60] : def_cu_q;
  assign ang_co = s_axis_tuser[2] ? s_axis_tdata[95:78] : def_co_q;
  assign ang_a  = SW'(ang_co);
  assign ang_b  = mode_q[bpsu_pkg::MODE_PZ_BIT] ? SW'(ang_g) + SW'(ang_cu) : SW'(ang_g);
  assign ang_c  = SW'(ang_cu);

  // Offsets ride a delay line beside the angle path.
  logic signed [OW-1:0] side_u_q [SIDE];
  logic signed [OW-1:0] side_v_q [SIDE];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_u_q[0] <= ofs_u;
      side_v_q[0] <= ofs_v;
      for (int k = 1; k < SIDE; k++) begin
        side_u_q[k] <= side_u_q[k-1];
        side_v_q[k] <= side_v_q[k-1];
      end
    end
  end

  // Three rows of CORDIC cells: collimator, gantry (or gantry plus couch), couch.
  logic signed [SW-1:0] row_ang [3];
  bpsu_pkg::cordic_t    chain [3][CORDIC_STAGES+1];

  assign row_ang[0] = ang_a;
  assign row_ang[1] = ang_b;
  assign row_ang[2] = ang_c;

  for (genvar a = 0; a < 3; a++) begin : g_row
    bpsu_angle_prep u_prep (
      .clk_i  (clk_i),
      .en_i   (adv),
      .ang_i  (row_ang[a]),
      .cell_o (chain[a][0])
    );
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
      bpsu_cordic_cell #(
        .STAGE (s)
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (adv),
        .cell_i (chain[a][s]),
        .cell_o (chain[a][s+1])
      );
    end
  end

  // Matrix build and origin.
  bpsu_pkg::frame_cfg_t frame_cfg;
  bpsu_pkg::result_t    res;

  assign frame_cfg.iso_x = iso_x_q;
  assign frame_cfg.iso_y = iso_y_q;
  assign frame_cfg.iso_z = iso_z_q;
  assign frame_cfg.sad   = sad_q;
  assign frame_cfg.mode  = mode_q;

  bpsu_frame #(
    .VECTOR_FRAC_BITS (VECTOR_FRAC_BITS)
  ) u_frame (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cfg_i   (frame_cfg),
    .col_i   (chain[0][CORDIC_STAGES]),
    .rot_i   (chain[1][CORDIC_STAGES]),
    .cou_i   (chain[2][CORDIC_STAGES]),
    .ofs_u_i (side_u_q[SIDE-1]),
    .ofs_v_i (side_v_q[SIDE-1]),
    .res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res};

  // A stalled output freezes the valid line.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
    else $error("valid line moved during an output stall");

  // An advancing pipeline shifts the accepted flag in.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted request missing from first stage");

  // The beam direction stays within the unit range.
  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.axis_w_x <= VEC_ONE && res.axis_w_x >= -VEC_ONE &&
                       res.axis_w_y <= VEC_ONE && res.axis_w_y >= -VEC_ONE &&
                       res.axis_w_z <= VEC_ONE && res.axis_w_z >= -VEC_ONE))
    else $error("beam direction component out of range");

endmodule

>>> dv/bpsu_checker.sv
// Checker of the beam source pose unit: predicts each pose and compares it with the output.
module bpsu_checker
  import bpsu_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int FRAC   = VECTOR_FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [IN_USER_W-1:0]  s_tuser_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [LEN_W-1:0]      cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef logic [8:0][63:0] mat_t;

  localparam longint UNIT = 64'sd1 <<< FRAC;

  // Our own copy of the configuration.
  longint iso [3];
  longint sad_len;
  logic [2:0] frame_mode;
  longint def_gantry, def_couch, def_collim;

  result_t pose_queue [$];
  string   field_names [12] = '{"origin_x", "origin_y", "origin_z", "axis_u_x", "axis_u_y",
    "axis_u_z", "axis_v_x", "axis_v_y", "axis_v_z", "axis_w_x", "axis_w_y", "axis_w_z"};

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unit_mul(longint a, longint b);
    return clip(round_shift(a * b, FRAC), -UNIT, UNIT);
  endfunction

  // Sine and cosine of a Q.8 degree angle through a rotation-mode CORDIC.
  function automatic void sin_cos(input longint a, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    logic neg;
    r = a % DEG_FULL;
    x = 64'sd2608131496;
    y = 0;
    neg = 1'b0;
    if (r < 0) r += DEG_FULL;
    if (r > DEG_HALF) r -= DEG_FULL;
    if (r > DEG_QUARTER) begin
      r -= DEG_HALF;
      neg = 1'b1;
    end else if (r < -DEG_QUARTER) begin
      r += DEG_HALF;
      neg = 1'b1;
    end
    z = r * 65536;
    for (int i = 0; i < (STAGES > 32 ? 32 : STAGES); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = clip(round_shift(x, WORK_FRAC - FRAC), -UNIT, UNIT);
    s = clip(round_shift(y, WORK_FRAC - FRAC), -UNIT, UNIT);
  endfunction

  function automatic mat_t mat_prod(mat_t a, mat_t b);
    mat_t o;
    longint acc;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += $signed(a[r*3+k]) * $signed(b[k*3+c]);
        o[r*3+c] = clip(round_shift(acc, FRAC), -UNIT, UNIT);
      end
    end
    return o;
  endfunction

  // Expected pose of one spot under the current configuration.
  function automatic result_t pose_of_spot(logic [IN_DATA_W-1:0] d, logic [IN_USER_W-1:0] u);
    longint ou, ov, g, cu, co, cc, sc, cz, sz, cg, sg, ux, vx, wx, acc;
    mat_t m, a, b;
    longint org [3];
    longint ax [9];
    result_t res;
    pos_e pos;
    ou = longint'($signed(d[20:0]));
    ov = longint'($signed(d[41:21]));
    g  = u[0] ? longint'($signed(d[59:42])) : def_gantry;
    cu = u[1] ? longint'($signed(d[77:60])) : def_couch;
    co = u[2] ? longint'($signed(d[95:78])) : def_collim;
    pos = pos_e'(frame_mode[1:0]);
    sin_cos(co, cc, sc);
    if (frame_mode[MODE_PZ_BIT]) begin
      sin_cos(g + cu, cz, sz);
      m = '{64'(-sc * 0), 64'(cc), 64'(-sc), 64'(-cz), 64'(unit_mul(sz, sc)),
            64'(unit_mul(sz, cc)), 64'(sz), 64'(unit_mul(cz, sc)), 64'(unit_mul(cz, cc))};
    end else begin
      // Collimator turn, then gantry about y, then couch about x.
      a = '{64'(UNIT), 64'(0), 64'(0), 64'(0), 64'(cc), 64'(-sc), 64'(0), 64'(sc), 64'(cc)};
      sin_cos(g, cg, sg);
      b = '{64'(cg), 64'(0), 64'(-sg), 64'(0), 64'(UNIT), 64'(0), 64'(sg), 64'(0), 64'(cg)};
      m = mat_prod(b, a);
      sin_cos(cu, cz, sz);
      a = '{64'(UNIT), 64'(0), 64'(0), 64'(0), 64'(cz), 64'(sz), 64'(0), 64'(-sz), 64'(cz)};
      m = mat_prod(a, m);
    end
    for (int r = 0; r < 3; r++) begin
      ux = $signed(m[r*3]);
      vx = $signed(m[r*3+1]);
      wx = -$signed(m[r*3+2]);
      if ((pos == POS_HFP && r != 2) || (pos == POS_FFS && r != 1) ||
          (pos == POS_FFP && r != 0)) begin
        ux = -ux; vx = -vx; wx = -wx;
      end
      acc = iso[r] * UNIT - sad_len * wx + ou * ux + ov * vx;
      org[r] = clip(round_shift(acc, FRAC), -64'sd67108864, 64'sd67108863);
      ax[r] = ux; ax[3+r] = vx; ax[6+r] = wx;
    end
    res.origin_x = org[0][ORG_W-1:0]; res.origin_y = org[1][ORG_W-1:0];
    res.origin_z = org[2][ORG_W-1:0];
    res.axis_u_x = ax[0][31:0]; res.axis_u_y = ax[1][31:0]; res.axis_u_z = ax[2][31:0];
    res.axis_v_x = ax[3][31:0]; res.axis_v_y = ax[4][31:0]; res.axis_v_z = ax[5][31:0];
    res.axis_w_x = ax[6][31:0]; res.axis_w_y = ax[7][31:0]; res.axis_w_z = ax[8][31:0];
    return res;
  endfunction

  function automatic longint field_of(result_t r, int i);
    case (i)
      0: return r.origin_x;  1: return r.origin_y;  2: return r.origin_z;
      3: return r.axis_u_x;  4: return r.axis_u_y;  5: return r.axis_u_z;
      6: return r.axis_v_x;  7: return r.axis_v_y;  8: return r.axis_v_z;
      9: return r.axis_w_x; 10: return r.axis_w_y; default: return r.axis_w_z;
    endcase
  endfunction

  assign pending_o = pose_queue.size();

  // Track register writes, predict accepted requests, compare accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      iso = '{0, 0, 0};
      sad_len = 0;
      frame_mode = '0;
      def_gantry = 0; def_couch = 0; def_collim = 0;
      fail_count_o = 0;
      pose_queue.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_ISO_X:      iso[0] = longint'($signed(cfg_data_i));
          REG_ISO_Y:      iso[1] = longint'($signed(cfg_data_i));
          REG_ISO_Z:      iso[2] = longint'($signed(cfg_data_i));
          REG_SAD:        sad_len = longint'(cfg_data_i);
          REG_FRAME_MODE: frame_mode = cfg_data_i[2:0];
          REG_DEF_GANTRY: def_gantry = longint'($signed(cfg_data_i[ANG_W-1:0]));
          REG_DEF_COUCH:  def_couch = longint'($signed(cfg_data_i[ANG_W-1:0]));
          default:        def_collim = longint'($signed(cfg_data_i[ANG_W-1:0]));
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        pose_queue.insert(pose_queue.size(), pose_of_spot(s_tdata_i, s_tuser_i));
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[$bits(result_t)-1:0]);
        if (pose_queue.size() == 0) begin
          if (fail_count_o < 10) $display("Unexpected result with no request pending");
          fail_count_o++;
        end else begin
          want = pose_queue.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (field_of(got, i) != field_of(want, i)) begin
              if (fail_count_o < 10)
                $display("Mismatch on %s: expected %0d, got %0d", field_names[i],
                         field_of(want, i), field_of(got, i));
              fail_count_o++;
            end
          end
        end
      end
    end
  end

endmodule

>>> dv/tb_beam_source_pose_unit.sv
// Testbench top of the beam source pose unit: stimulus, stalls, watchdog and verdict.
module tb_beam_source_pose_unit;
  import bpsu_pkg::*;

  localparam int LATENCY   = CORDIC_STAGES_DEF + 10;
  localparam int IDLE_LIMIT = 4000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_index_i = '0;
  logic [LEN_W-1:0]      cfg_data_i = '0;
  int                    fail_count, pending;
  int                    idle_cycles = 0;

  beam_source_pose_unit DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  bpsu_checker checker_i (
    .clk_i, .rst_ni, .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser), .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata), .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver stalls: the pattern switches among always ready, coin flips and long stalls.
  always @(negedge clk_i) begin
    int unsigned phase;
    phase = ($time / 2400) % 3;
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (phase == 0) m_axis_tready <= 1'b1;
    else if (phase == 1) m_axis_tready <= $urandom_range(0, 1);
    else m_axis_tready <= ($urandom_range(0, 15) != 0) ? m_axis_tready : ~m_axis_tready;
  end

  // Watchdog on cycles in which no request moves on either channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [ANG_W-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return ANG_W'($urandom);
      1: return ($urandom_range(0, 1)) ? ANG_W'(DEG_FULL) : ANG_W'(-DEG_FULL);
      2: return ANG_W'(DEG_QUARTER * $urandom_range(0, 8) - 4 * DEG_QUARTER);
      default: return ANG_W'($urandom_range(0, 2 * DEG_FULL) - DEG_FULL);
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [LEN_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_spot(logic [20:0] ou, logic [20:0] ov, logic [ANG_W-1:0] g,
                           logic [ANG_W-1:0] cu, logic [ANG_W-1:0] co, logic [2:0] given);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {co, cu, g, ov, ou};
    s_axis_tuser = given;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Called at a falling edge; the sender stops at once and waits for every result.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic random_spots(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && count > 0; i++, count--)
        send_spot(21'($urandom), 21'($urandom), pick_angle(), pick_angle(), pick_angle(),
                  3'($urandom));
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    logic [ANG_W-1:0] ext [6];
    ext = '{ANG_W'(-DEG_FULL), ANG_W'(DEG_FULL), ANG_W'(0), ANG_W'(DEG_QUARTER),
            ANG_W'(DEG_HALF), ANG_W'(-DEG_QUARTER)};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed spots under reset settings, then with extreme registers.
    @(negedge clk_i);
    for (int i = 0; i < 6; i++)
      send_spot(21'h100000, 21'h0FFFFF, ext[i], ext[5-i], ext[(i+2)%6], 3'b111);
    send_spot(21'h0FFFFF, 21'h100000, 18'h1FFFF, 18'h20000, 18'h3FFFF, 3'b111);
    send_spot(21'h1FFFFF, 21'h000000, 18'h20000, 18'h1FFFF, 18'h00000, 3'b111);
    drain();
    write_reg(REG_ISO_X, 24'h7FFFFF);
    write_reg(REG_ISO_Y, 24'h800000);
    write_reg(REG_ISO_Z, 24'h7FFFFF);
    write_reg(REG_SAD, 24'hFFFFFF);
    write_reg(REG_FRAME_MODE, LEN_W'(POS_FFP));
    write_reg(REG_DEF_GANTRY, LEN_W'(DEG_QUARTER));
    write_reg(REG_DEF_COUCH, LEN_W'(-DEG_FULL));
    write_reg(REG_DEF_COLLIM, LEN_W'(DEG_FULL));
    @(negedge clk_i);
    for (int i = 0; i < 8; i++)
      send_spot(i[0] ? 21'h0FFFFF : 21'h100000, i[1] ? 21'h0FFFFF : 21'h100000,
                ext[i%6], ext[(i+1)%6], ext[(i+3)%6], i[2:0]);
    drain();

    // Random phases, one per frame mode; the sender waits for a drain between them.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ISO_X, (ph == 7) ? 24'h800000 : LEN_W'($urandom));
      write_reg(REG_ISO_Y, (ph == 7) ? 24'h7FFFFF : LEN_W'($urandom));
      write_reg(REG_ISO_Z, (ph == 7) ? 24'h800000 : LEN_W'($urandom));
      write_reg(REG_SAD, (ph == 0) ? 24'h000000 : LEN_W'($urandom));
      write_reg(REG_FRAME_MODE, LEN_W'(ph));
      write_reg(REG_DEF_GANTRY, LEN_W'($signed(pick_angle())));
      write_reg(REG_DEF_COUCH, LEN_W'($signed(pick_angle())));
      write_reg(REG_DEF_COLLIM, LEN_W'($signed(pick_angle())));
      @(negedge clk_i);
      random_spots(200);
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/bpsu_pkg.sv
hdl/bpsu_angle_prep.sv
hdl/bpsu_cordic_cell.sv
hdl/bpsu_frame.sv
hdl/beam_source_pose_unit.sv
dv/bpsu_checker.sv
dv/tb_beam_source_pose_unit.sv
